/* hw/rtl/rc_capacitance_meter_autorange_unit_macros.svh */
// Assertion helpers used by the checker file.
`ifndef RC_CAPACITANCE_METER_AUTORANGE_UNIT_MACROS_SVH
`define RC_CAPACITANCE_METER_AUTORANGE_UNIT_MACROS_SVH

// Clocked check, off while reset is held.
`define RCM_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that applies to every item on the result channel.
`define RCM_ASSERT_OUT(label, prop, msg) \
    `RCM_ASSERT_CLK(label, o_out_valid |-> (prop), msg)

`endif

/* hw/rtl/rcm_pkg.sv */
package rcm_pkg;

    localparam int ADC_BITS   = 10;
    localparam int TIMER_BITS = 32;
    localparam int TIME_BITS  = 32;
    localparam int CAP_BITS   = 42;
    localparam int PF_BITS    = 10;
    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 32;

    localparam logic [TIME_BITS-1:0] OUT_TIME_MAX = '1;

    // register indexes, paddr[3:2]
    localparam logic [1:0] REG_CHARGE_LEVEL = 2'd0;
    localparam logic [1:0] REG_EMPTY_LEVEL  = 2'd1;
    localparam logic [1:0] REG_RANGE1_MIN   = 2'd2;
    localparam logic [1:0] REG_RANGE2_MIN   = 2'd3;

    localparam logic [ADC_BITS-1:0]  CHARGE_LEVEL_RST = ADC_BITS'(648);
    localparam logic [ADC_BITS-1:0]  EMPTY_LEVEL_RST  = '0;
    localparam logic [TIME_BITS-1:0] RANGE1_MIN_RST   = TIME_BITS'(99990);
    localparam logic [TIME_BITS-1:0] RANGE2_MIN_RST   = TIME_BITS'(9990);

    // range codes
    localparam logic [1:0] RANGE_1K   = 2'd0;
    localparam logic [1:0] RANGE_100K = 2'd1;
    localparam logic [1:0] RANGE_1M   = 2'd2;

    // charge drive with no resistor selected
    localparam logic [1:0] CHARGE_NONE = 2'd0;

    typedef enum logic {
        PH_CHARGE    = 1'b0,
        PH_DISCHARGE = 1'b1
    } t_phase;

    typedef struct packed {
        logic [ADC_BITS-1:0]  charge_level;
        logic [ADC_BITS-1:0]  empty_level;
        logic [TIME_BITS-1:0] range1_min_time;
        logic [TIME_BITS-1:0] range2_min_time;
    } t_cfg;

    typedef struct packed {
        logic [1:0]           charge_select;
        logic                 discharge_on;
        logic                 result_valid;
        logic [1:0]           range_used;
        logic [TIME_BITS-1:0] charge_time;
        logic [CAP_BITS-1:0]  capacitance_pf;
    } t_result;

    // picofarads per microsecond tick: 1e6 / R
    function automatic logic [PF_BITS-1:0] pf_per_tick(input logic [1:0] rng);
        logic [PF_BITS-1:0] f;
        case (rng)
            RANGE_1K:   f = PF_BITS'(1000);
            RANGE_100K: f = PF_BITS'(10);
            default:    f = PF_BITS'(1);
        endcase
        return f;
    endfunction

endpackage

/* hw/rtl/rc_capacitance_meter_autorange_unit.sv */
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+----------------------------------------
// sample in | in        | i_in_valid / o_in_stall | i_adc_sample
// result    | out       | o_out_valid / i_out_stall | o_charge_select .. o_capacitance_pf
// config    | in        | APB psel/penable/pready | paddr, pwdata, prdata
//
// One item per clock while o_in_stall is low; results go to a registered output buffer.
// Sequencing state updates at acceptance; a two-entry output buffer holds results,
// so o_in_stall rises only once both entries are full.
// Synchronous active-low reset clears the sequencer, the buffer and the registers.
module rc_capacitance_meter_autorange_unit import rcm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ADC_BITS-1:0]   i_adc_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_charge_select,
    output logic                  o_discharge_on,
    output logic                  o_result_valid,
    output logic [1:0]            o_range_used,
    output logic [TIME_BITS-1:0]  o_charge_time,
    output logic [CAP_BITS-1:0]   o_capacitance_pf,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    t_cfg    r_cfg;
    t_result core_result;
    t_result out_item;
    logic    in_fire;
    logic    cfg_write;
    logic [1:0] reg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.charge_level    <= CHARGE_LEVEL_RST;
            r_cfg.empty_level     <= EMPTY_LEVEL_RST;
            r_cfg.range1_min_time <= RANGE1_MIN_RST;
            r_cfg.range2_min_time <= RANGE2_MIN_RST;
        end else if (cfg_write) begin
            case (reg_index)
                REG_CHARGE_LEVEL: r_cfg.charge_level    <= pwdata[ADC_BITS-1:0];
                REG_EMPTY_LEVEL:  r_cfg.empty_level     <= pwdata[ADC_BITS-1:0];
                REG_RANGE1_MIN:   r_cfg.range1_min_time <= pwdata[TIME_BITS-1:0];
                REG_RANGE2_MIN:   r_cfg.range2_min_time <= pwdata[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_CHARGE_LEVEL: prdata = PDATA_BITS'(r_cfg.charge_level);
            REG_EMPTY_LEVEL:  prdata = PDATA_BITS'(r_cfg.empty_level);
            REG_RANGE1_MIN:   prdata = PDATA_BITS'(r_cfg.range1_min_time);
            REG_RANGE2_MIN:   prdata = PDATA_BITS'(r_cfg.range2_min_time);
            default:          prdata = '0;
        endcase
    end

    assign in_fire = i_in_valid && !o_in_stall;

    rcm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_adc_sample (i_adc_sample),
        .i_cfg        (r_cfg),
        .o_result     (core_result)
    );

    rcm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (core_result),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (out_item)
    );

    assign o_charge_select  = out_item.charge_select;
    assign o_discharge_on   = out_item.discharge_on;
    assign o_result_valid   = out_item.result_valid;
    assign o_range_used     = out_item.range_used;
    assign o_charge_time    = out_item.charge_time;
    assign o_capacitance_pf = out_item.capacitance_pf;

endmodule

/* hw/rtl/rcm_core.sv */
module rcm_core import rcm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [ADC_BITS-1:0] i_adc_sample,
    input  t_cfg                i_cfg,
    output t_result             o_result
);

    t_phase                r_phase, n_phase;
    logic [1:0]            r_range_index, n_range_index;
    logic [TIMER_BITS-1:0] r_tick_count, n_tick_count;
    logic [TIMER_BITS-1:0] r_held_time, n_held_time;
    logic                  r_accept, n_accept;

    logic [1:0]            range_eff;
    logic [TIMER_BITS-1:0] tick_inc;
    logic [63:0]           held_ext;
    logic [TIME_BITS-1:0]  time_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_CHARGE;
            r_range_index <= RANGE_1K;
            r_tick_count  <= '0;
            r_held_time   <= '0;
            r_accept      <= 1'b0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_range_index <= n_range_index;
            r_tick_count  <= n_tick_count;
            r_held_time   <= n_held_time;
            r_accept      <= n_accept;
        end
    end

    always_comb begin
        range_eff = (r_range_index > RANGE_1M) ? RANGE_1M : r_range_index;
        tick_inc  = (&r_tick_count) ? r_tick_count : r_tick_count + 1'b1;
        held_ext  = 64'(r_held_time);
        time_sat  = (held_ext > 64'(OUT_TIME_MAX)) ? OUT_TIME_MAX : held_ext[TIME_BITS-1:0];

        n_phase       = r_phase;
        n_range_index = r_range_index;
        n_tick_count  = r_tick_count;
        n_held_time   = r_held_time;
        n_accept      = r_accept;
        o_result      = '0;

        case (r_phase)
            PH_CHARGE: begin
                o_result.charge_select = range_eff + 2'd1;
                n_tick_count = tick_inc;
                if (i_adc_sample >= i_cfg.charge_level) begin
                    n_held_time = tick_inc;
                    n_phase     = PH_DISCHARGE;
                    case (range_eff)
                        RANGE_1K:   n_accept = 64'(tick_inc) > 64'(i_cfg.range1_min_time);
                        RANGE_100K: n_accept = 64'(tick_inc) > 64'(i_cfg.range2_min_time);
                        default:    n_accept = 1'b1;
                    endcase
                end
            end
            PH_DISCHARGE: begin
                o_result.discharge_on = 1'b1;
                if (i_adc_sample <= i_cfg.empty_level) begin
                    if (r_accept) begin
                        o_result.result_valid   = 1'b1;
                        o_result.range_used     = range_eff;
                        o_result.charge_time    = time_sat;
                        o_result.capacitance_pf = CAP_BITS'(time_sat) *
                                                  CAP_BITS'(pf_per_tick(range_eff));
                        n_range_index = RANGE_1K;
                    end else begin
                        n_range_index = range_eff + 2'd1;
                    end
                    n_phase      = PH_CHARGE;
                    n_tick_count = '0;
                    n_accept     = 1'b0;
                end
            end
            default: begin
                n_phase = PH_CHARGE;
            end
        endcase
    end

endmodule

/* hw/rtl/rcm_skid.sv */
module rcm_skid import rcm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_result i_item,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_item
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    in_fire;

    assign o_stall = r_skid_valid;
    assign in_fire = i_valid && !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (r_out_valid && i_stall) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_valid && i_stall) begin
                r_skid <= i_item;
            end else begin
                r_out <= i_item;
            end
        end
    end

endmodule

/* hw/rtl/rcm_checker.sv */
`include "rc_capacitance_meter_autorange_unit_macros.svh"

module rcm_checker import rcm_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [1:0]            o_charge_select,
    input logic                  o_discharge_on,
    input logic                  o_result_valid,
    input logic [1:0]            o_range_used,
    input logic [TIME_BITS-1:0]  o_charge_time,
    input logic [CAP_BITS-1:0]   o_capacitance_pf
);

    logic                out_held;
    logic                in_discharge;
    logic                fields_clear;
    logic                range_ok;
    logic [CAP_BITS-1:0] cap_want;

    assign out_held     = o_out_valid && i_out_stall;
    assign in_discharge = o_discharge_on && o_charge_select == CHARGE_NONE;
    assign fields_clear = o_range_used == '0 && o_charge_time == '0 &&
                          o_capacitance_pf == '0;
    assign range_ok     = o_range_used <= RANGE_1M;
    assign cap_want     = CAP_BITS'(o_charge_time) * CAP_BITS'(pf_per_tick(o_range_used));

    `RCM_ASSERT_CLK(a_out_hold, out_held |=> o_out_valid, "result item dropped under stall")

    // a measurement only completes while discharging
    `RCM_ASSERT_OUT(a_result_in_discharge, !o_result_valid || in_discharge,
                    "result outside discharge")

    `RCM_ASSERT_OUT(a_idle_fields_zero, o_result_valid || fields_clear,
                    "idle item carries result fields")

    `RCM_ASSERT_OUT(a_cap_scale,
                    !o_result_valid || (range_ok && o_capacitance_pf == cap_want),
                    "capacitance does not match time and range")

endmodule

bind rc_capacitance_meter_autorange_unit rcm_checker u_rcm_checker (.*);

/* tb/sv/rc_capacitance_meter_autorange_unit_tb.sv */
`timescale 1ns / 1ps

module rc_capacitance_meter_autorange_unit_tb;
    import rcm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int PHASES         = 8;
    localparam int PHASE_SAMPLES  = 204;

    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_GAPS,
        FLOW_RECEIVER_STALLS,
        FLOW_BOTH
    } t_flow;

    // Tracks the sequencer and holds the readings still owed by the block.
    class meter_scoreboard;
        t_cfg                  cfg;
        t_phase                ph;
        logic [1:0]            range_idx;
        logic [TIMER_BITS-1:0] ticks;
        logic [TIMER_BITS-1:0] held;
        logic                  accepted;
        t_result               awaited[$];
        int                    mismatches;
        int                    checked;
        int                    per_range[3];

        function new();
            cfg = '{charge_level: CHARGE_LEVEL_RST, empty_level: EMPTY_LEVEL_RST,
                    range1_min_time: RANGE1_MIN_RST, range2_min_time: RANGE2_MIN_RST};
            ph         = PH_CHARGE;
            range_idx  = RANGE_1K;
            ticks      = '0;
            held       = '0;
            accepted   = 1'b0;
            mismatches = 0;
            checked    = 0;
            per_range  = '{0, 0, 0};
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 20)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        function t_result forecast_reading(logic [ADC_BITS-1:0] s);
            t_result             r;
            logic [1:0]          rng;
            logic [CAP_BITS-1:0] scale;
            r   = '0;
            rng = (range_idx > RANGE_1M) ? RANGE_1M : range_idx;
            if (ph == PH_CHARGE) begin
                r.charge_select = rng + 2'd1;
                if (ticks != '1)
                    ticks = ticks + 1'b1;
                // the tick that reaches the level is still counted and still charging
                if (s >= cfg.charge_level) begin
                    held = ticks;
                    case (rng)
                        RANGE_1K:   accepted = held > cfg.range1_min_time;
                        RANGE_100K: accepted = held > cfg.range2_min_time;
                        default:    accepted = 1'b1;
                    endcase
                    ph = PH_DISCHARGE;
                end
            end else begin
                r.discharge_on = 1'b1;
                if (s <= cfg.empty_level) begin
                    if (accepted) begin
                        case (rng)
                            RANGE_1K:   scale = CAP_BITS'(1000);
                            RANGE_100K: scale = CAP_BITS'(10);
                            default:    scale = CAP_BITS'(1);
                        endcase
                        r.result_valid   = 1'b1;
                        r.range_used     = rng;
                        r.charge_time    = (held > OUT_TIME_MAX) ? OUT_TIME_MAX
                                                                 : TIME_BITS'(held);
                        r.capacitance_pf = CAP_BITS'(r.charge_time) * scale;
                        range_idx        = RANGE_1K;
                    end else begin
                        // too short for this resistor, try the next one
                        range_idx = rng + 2'd1;
                    end
                    ph       = PH_CHARGE;
                    ticks    = '0;
                    accepted = 1'b0;
                end
            end
            return r;
        endfunction

        function void note_sample(logic [ADC_BITS-1:0] s);
            awaited.push_back(forecast_reading(s));
        endfunction

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("reading %0d %s: got %0h, want %0h",
                                          checked, name, got, want));
        endtask

        task check_reading(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("reading %0d arrived with none owed", checked));
            end else begin
                want = awaited.pop_front();
                compare_field("charge_select", 64'(got.charge_select),
                              64'(want.charge_select));
                compare_field("discharge_on", 64'(got.discharge_on),
                              64'(want.discharge_on));
                compare_field("result_valid", 64'(got.result_valid),
                              64'(want.result_valid));
                compare_field("range_used", 64'(got.range_used), 64'(want.range_used));
                compare_field("charge_time", 64'(got.charge_time), 64'(want.charge_time));
                compare_field("capacitance_pf", 64'(got.capacitance_pf),
                              64'(want.capacitance_pf));
                if (want.result_valid)
                    per_range[want.range_used]++;
            end
            checked++;
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [ADC_BITS-1:0]   i_adc_sample = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_charge_select;
    logic                  o_discharge_on;
    logic                  o_result_valid;
    logic [1:0]            o_range_used;
    logic [TIME_BITS-1:0]  o_charge_time;
    logic [CAP_BITS-1:0]   o_capacitance_pf;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_BITS-1:0] paddr = '0;
    logic [PDATA_BITS-1:0] pwdata = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    meter_scoreboard sb;
    int sender_idle_pct  = 0;
    int stall_pct        = 0;
    int samples_sent     = 0;
    int settings_applied = 0;
    int stuck_cycles     = 0;
    int holdoff_requests = 0;
    int holdoff_served   = 0;
    int holdoff_left     = 0;

    rc_capacitance_meter_autorange_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_adc_sample     (i_adc_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_charge_select  (o_charge_select),
        .o_discharge_on   (o_discharge_on),
        .o_result_valid   (o_result_valid),
        .o_range_used     (o_range_used),
        .o_charge_time    (o_charge_time),
        .o_capacitance_pf (o_capacitance_pf),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (holdoff_requests != holdoff_served) begin
            holdoff_served = holdoff_requests;
            holdoff_left   = HOLDOFF_CYCLES;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (holdoff_left > 0) begin
            i_out_stall <= 1'b1;
            holdoff_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // both channels and the watchdog; samples are noted before readings are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_sample(i_adc_sample);
            if (o_out_valid && !i_out_stall)
                sb.check_reading({o_charge_select, o_discharge_on, o_result_valid,
                                  o_range_used, o_charge_time, o_capacitance_pf});
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                sb.report_mismatch("no item moved on either channel, run stuck");
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic push_sample(input logic [ADC_BITS-1:0] s);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_adc_sample <= s;
        do @(posedge i_clk); while (o_in_stall);
        samples_sent++;
    endtask

    task automatic drain_readings();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [PDATA_BITS-1:0] wdata,
                               input logic [PDATA_BITS-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        // read back
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            sb.report_mismatch($sformatf("register %0d reads %0h, want %0h",
                                         idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        drain_readings();
        repeat (2) @(posedge i_clk);
        // junk above the 10-bit levels must be dropped
        program_reg(REG_CHARGE_LEVEL, {22'($urandom), c.charge_level}, 32'(c.charge_level));
        program_reg(REG_EMPTY_LEVEL, {22'($urandom), c.empty_level}, 32'(c.empty_level));
        program_reg(REG_RANGE1_MIN, c.range1_min_time, c.range1_min_time);
        program_reg(REG_RANGE2_MIN, c.range2_min_time, c.range2_min_time);
        sb.cfg = c;
        settings_applied++;
    endtask

    task automatic set_flow(input t_flow f);
        case (f)
            FLOW_FREE:            begin sender_idle_pct = 0;  stall_pct = 0;  end
            FLOW_SENDER_GAPS:     begin sender_idle_pct = 54; stall_pct = 0;  end
            FLOW_RECEIVER_STALLS: begin sender_idle_pct = 0;  stall_pct = 54; end
            default:              begin sender_idle_pct = 29; stall_pct = 29; end
        endcase
    endtask

    function automatic logic [TIME_BITS-1:0] random_min_time();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return TIME_BITS'($urandom);
            default: return TIME_BITS'($urandom_range(0, 12));
        endcase
    endfunction

    function automatic t_cfg random_settings();
        t_cfg c;
        case ($urandom_range(5))
            0:       c.charge_level = '0;
            1:       c.charge_level = '1;
            default: c.charge_level = ADC_BITS'($urandom_range(1, 1022));
        endcase
        case ($urandom_range(5))
            0:       c.empty_level = '0;
            1:       c.empty_level = '1;
            default: c.empty_level = ADC_BITS'($urandom_range(0, 400));
        endcase
        c.range1_min_time = random_min_time();
        c.range2_min_time = random_min_time();
        return c;
    endfunction

    // one charge/discharge pass with random lengths, relative to the current levels
    task automatic run_measurement();
        int n;
        logic [ADC_BITS-1:0] lvl;
        n   = $urandom_range(0, 14);
        lvl = sb.cfg.charge_level;
        repeat (n)
            push_sample(lvl == '0 ? ADC_BITS'($urandom) : ADC_BITS'($urandom_range(0, lvl - 1)));
        push_sample(ADC_BITS'($urandom_range(lvl, 1023)));
        n   = $urandom_range(0, 4);
        lvl = sb.cfg.empty_level;
        repeat (n)
            push_sample(lvl == '1 ? ADC_BITS'($urandom)
                                  : ADC_BITS'($urandom_range(lvl + 1, 1023)));
        push_sample(ADC_BITS'($urandom_range(0, lvl)));
    endtask

    initial begin
        int  seq_a[9] = '{1023, 0, 700, 0, 500, 647, 648, 1, 0};
        int  seq_b[4] = '{0, 1023, 1023, 512};
        int  seq_c[7] = '{1022, 1023, 5, 1023, 0, 1023, 1023};
        int  phase_end;
        bit  mid_done;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset levels: 1k and 100k rejected, 1M accepted after three ticks
        foreach (seq_a[k]) push_sample(ADC_BITS'(seq_a[k]));
        // levels at the extremes, every time long enough
        apply_settings('{charge_level: '0, empty_level: '1,
                         range1_min_time: '0, range2_min_time: '0});
        foreach (seq_b[k]) push_sample(ADC_BITS'(seq_b[k]));
        // nothing is ever long enough below the 1M range
        apply_settings('{charge_level: '1, empty_level: '1,
                         range1_min_time: '1, range2_min_time: '1});
        foreach (seq_c[k]) push_sample(ADC_BITS'(seq_c[k]));

        for (int p = 0; p < PHASES; p++) begin
            apply_settings(random_settings());
            set_flow(t_flow'(p % 4));
            phase_end = samples_sent + PHASE_SAMPLES;
            mid_done  = 1'b0;
            while (samples_sent < phase_end) begin
                if (!mid_done && samples_sent + PHASE_SAMPLES / 2 >= phase_end) begin
                    mid_done = 1'b1;
                    if (p % 2 == 0)
                        holdoff_requests++;
                    else
                        drain_readings();
                end
                if ($urandom_range(99) < 80)
                    run_measurement();
                else
                    repeat ($urandom_range(1, 6)) push_sample(ADC_BITS'($urandom));
            end
        end

        drain_readings();
        repeat (4) @(posedge i_clk);
        $display("Checked %0d ticks from %0d ADC samples over %0d register settings.",
                 sb.checked, samples_sent, settings_applied);
        $display("Completed measurements 1k/100k/1M: %0d/%0d/%0d, mismatches: %0d",
                 sb.per_range[0], sb.per_range[1], sb.per_range[2], sb.mismatches);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
